>>> design/utc_pkg.sv
// ----------------------------------------------------------------------------
// utc_pkg: shared types and helpers of the code unit transcoder
// Encoding and error codes, register indexes, the run record that the
// front end hands to the back end, and the code point encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utc_pkg;

  localparam int UnitW      = 32;
  localparam int CpW        = 21;
  localparam int CapW       = 16;
  localparam int CfgW       = 16;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CpW-1:0] CpMax = 21'h10FFFF;

  typedef enum logic [1:0] {
    ENC_ASCII = 2'd0,
    ENC_UTF8  = 2'd1,
    ENC_UTF16 = 2'd2,
    ENC_UTF32 = 2'd3
  } utc_enc_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_ASCII_HIGH  = 3'd1,
    ERR_UNENCODABLE = 3'd2,
    ERR_BAD_UTF8    = 3'd3,
    ERR_BAD_UTF16   = 3'd4,
    ERR_BAD_UTF32   = 3'd5,
    ERR_FULL        = 3'd6,
    ERR_TRUNCATED   = 3'd7
  } utc_err_e;

  localparam logic [1:0] CFG_SOURCE_ENC = 2'd0;
  localparam logic [1:0] CFG_TARGET_ENC = 2'd1;
  localparam logic [1:0] CFG_TARGET_CAP = 2'd2;

  typedef struct packed {
    utc_enc_e        src_enc;
    utc_enc_e        tgt_enc;
    logic [CapW-1:0] cap;
  } utc_cfg_t;

  // Units of one code point in the target encoding.
  typedef struct packed {
    logic [3:0][UnitW-1:0] units;
    logic [1:0]            last_idx;
  } utc_code_t;

  // One queued run: all results caused by one accepted input item.
  typedef struct packed {
    logic [3:0][UnitW-1:0] units;
    logic [1:0]            last_idx;
    logic                  fin;
    utc_err_e              err;
  } utc_run_t;

  function automatic logic utc_cp_valid(input logic [UnitW-1:0] cp);
    logic in_range;
    logic surrogate;
    in_range  = cp <= {11'd0, CpMax};
    surrogate = (cp >= 32'h0000_D800) && (cp <= 32'h0000_DFFF);
    return in_range && !surrogate;
  endfunction

  function automatic utc_code_t utc_encode(input logic [CpW-1:0] cp, input utc_enc_e enc);
    utc_code_t res;
    res.units    = '0;
    res.last_idx = 2'd0;
    unique case (enc) inside
      ENC_ASCII, ENC_UTF32: begin
        res.units[0] = {11'd0, cp};
      end
      ENC_UTF16: begin
        if (cp > 21'h00FFFF) begin
          res.units[0] = {21'd0, cp[20:10]} + 32'h0000_D7C0;
          res.units[1] = {22'd0, cp[9:0]} + 32'h0000_DC00;
          res.last_idx = 2'd1;
        end else begin
          res.units[0] = {11'd0, cp};
        end
      end
      default: begin
        if (cp < 21'h80) begin
          res.units[0] = {11'd0, cp};
        end else if (cp < 21'h800) begin
          res.units[0] = {24'd0, 3'b110, cp[10:6]};
          res.units[1] = {24'd0, 2'b10, cp[5:0]};
          res.last_idx = 2'd1;
        end else if (cp < 21'h10000) begin
          res.units[0] = {24'd0, 4'b1110, cp[15:12]};
          res.units[1] = {24'd0, 2'b10, cp[11:6]};
          res.units[2] = {24'd0, 2'b10, cp[5:0]};
          res.last_idx = 2'd2;
        end else begin
          res.units[0] = {24'd0, 5'b11110, cp[20:18]};
          res.units[1] = {24'd0, 2'b10, cp[17:12]};
          res.units[2] = {24'd0, 2'b10, cp[11:6]};
          res.units[3] = {24'd0, 2'b10, cp[5:0]};
          res.last_idx = 2'd3;
        end
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/utc_front.sv
// ----------------------------------------------------------------------------
// utc_front: decoder, validator and encoder of the transcoder
// Accepts one source unit per cycle while accept_i is high, updates the decode
// state and pushes the complete run of results for that unit, if it causes any,
// into the queue.
`default_nettype none

module utc_front import utc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire utc_cfg_t         cfg_i,
  input  wire logic             src_enc_wr_i,
  input  wire logic             accept_i,
  input  wire logic [UnitW-1:0] source_unit_i,
  input  wire logic             final_unit_i,
  output logic                  push_o,
  output utc_run_t              push_data_o
);

  logic [CpW-1:0]  pcp_q, pcp_d;
  logic [1:0]      cont_q, cont_d;
  logic [2:0]      seq_len_q, seq_len_d;
  logic [9:0]      lead_q, lead_d;
  logic            lead_pend_q, lead_pend_d;
  logic [CapW-1:0] written_q, written_d;
  logic            err_latch_q, err_latch_d;

  // Decode results for the current unit.
  logic [CpW-1:0]  dec_pcp;
  logic [1:0]      dec_cont;
  logic [2:0]      dec_seq_len;
  logic [9:0]      dec_lead;
  logic            dec_lead_pend;
  logic [CpW-1:0]  cp;
  logic            have;
  utc_err_e        err;
  logic [CpW-1:0]  acc;
  logic [7:0]      byte_in;
  logic [15:0]     word_in;
  logic            is_lead;
  logic            is_trail;
  logic            overlong;
  utc_code_t       code;
  logic [CapW:0]   new_total;
  logic            emit;

  assign byte_in  = source_unit_i[7:0];
  assign word_in  = source_unit_i[15:0];
  assign is_lead  = word_in[15:10] == 6'b110110;
  assign is_trail = word_in[15:10] == 6'b110111;
  assign acc      = {pcp_q[14:0], byte_in[5:0]};
  assign overlong = ((seq_len_q == 3'd2) && (acc < 21'h80))
                 || ((seq_len_q == 3'd3) && (acc < 21'h800))
                 || ((seq_len_q == 3'd4) && (acc < 21'h10000));

  always_comb begin
    dec_pcp       = pcp_q;
    dec_cont      = cont_q;
    dec_seq_len   = seq_len_q;
    dec_lead      = lead_q;
    dec_lead_pend = lead_pend_q;
    cp            = '0;
    have          = 1'b0;
    err           = ERR_NONE;
    unique case (cfg_i.src_enc)
      ENC_ASCII: begin
        if (byte_in[7]) begin
          err = ERR_ASCII_HIGH;
        end else begin
          cp   = {13'd0, byte_in};
          have = 1'b1;
        end
      end
      ENC_UTF8: begin
        if (cont_q == 2'd0) begin
          if (!byte_in[7]) begin
            cp   = {13'd0, byte_in};
            have = 1'b1;
          end else if (byte_in[7:5] == 3'b110) begin
            dec_pcp     = {16'd0, byte_in[4:0]};
            dec_cont    = 2'd1;
            dec_seq_len = 3'd2;
          end else if (byte_in[7:4] == 4'b1110) begin
            dec_pcp     = {17'd0, byte_in[3:0]};
            dec_cont    = 2'd2;
            dec_seq_len = 3'd3;
          end else if (byte_in[7:3] == 5'b11110) begin
            dec_pcp     = {18'd0, byte_in[2:0]};
            dec_cont    = 2'd3;
            dec_seq_len = 3'd4;
          end else begin
            err = ERR_BAD_UTF8;
          end
        end else if (byte_in[7:6] != 2'b10) begin
          err = ERR_BAD_UTF8;
        end else begin
          dec_cont = cont_q - 2'd1;
          if (cont_q == 2'd1) begin
            dec_pcp     = '0;
            dec_seq_len = 3'd0;
            if (!utc_cp_valid({11'd0, acc}) || overlong) begin
              err = ERR_BAD_UTF8;
            end else begin
              cp   = acc;
              have = 1'b1;
            end
          end else begin
            dec_pcp = acc;
          end
        end
      end
      ENC_UTF16: begin
        if (lead_pend_q) begin
          if (!is_trail) begin
            err = ERR_BAD_UTF16;
          end else begin
            cp            = 21'h10000 + {1'b0, lead_q, word_in[9:0]};
            have          = 1'b1;
            dec_lead_pend = 1'b0;
            dec_lead      = '0;
          end
        end else if (is_lead) begin
          dec_lead      = word_in[9:0];
          dec_lead_pend = 1'b1;
        end else if (is_trail) begin
          err = ERR_BAD_UTF16;
        end else begin
          cp   = {5'd0, word_in};
          have = 1'b1;
        end
      end
      default: begin
        if (utc_cp_valid(source_unit_i)) begin
          cp   = source_unit_i[CpW-1:0];
          have = 1'b1;
        end else begin
          err = ERR_BAD_UTF32;
        end
      end
    endcase

    // A string that ends inside a sequence is truncated (UTF-16 reports it as bad UTF-16).
    if ((err == ERR_NONE) && !have && final_unit_i) begin
      err = (cfg_i.src_enc == ENC_UTF8) ? ERR_TRUNCATED : ERR_BAD_UTF16;
    end
  end

  assign code      = utc_encode(cp, cfg_i.tgt_enc);
  assign new_total = {1'b0, written_q} + {14'd0, {1'b0, code.last_idx} + 3'd1};

  always_comb begin
    utc_err_e fin_err;
    fin_err = err;
    emit    = 1'b0;
    if ((err == ERR_NONE) && have) begin
      if ((cfg_i.tgt_enc == ENC_ASCII) && (cp[CpW-1:7] != '0)) begin
        fin_err = ERR_UNENCODABLE;
      end else if (new_total > {1'b0, cfg_i.cap}) begin
        fin_err = ERR_FULL;
      end else begin
        emit = 1'b1;
      end
    end

    push_data_o.units    = '0;
    push_data_o.last_idx = 2'd0;
    push_data_o.fin      = final_unit_i;
    push_data_o.err      = ERR_NONE;
    push_o               = 1'b0;
    if (err_latch_q) begin
      // Rest of the string is dropped; only its end is reported.
      push_o = accept_i && final_unit_i;
    end else if (emit) begin
      push_o               = accept_i;
      push_data_o.units    = code.units;
      push_data_o.last_idx = code.last_idx;
    end else if (fin_err != ERR_NONE) begin
      push_o          = accept_i;
      push_data_o.err = fin_err;
    end

    pcp_d       = pcp_q;
    cont_d      = cont_q;
    seq_len_d   = seq_len_q;
    lead_d      = lead_q;
    lead_pend_d = lead_pend_q;
    written_d   = written_q;
    err_latch_d = err_latch_q;
    if (src_enc_wr_i) begin
      pcp_d       = '0;
      cont_d      = '0;
      seq_len_d   = '0;
      lead_d      = '0;
      lead_pend_d = 1'b0;
    end else if (accept_i) begin
      if (final_unit_i) begin
        pcp_d       = '0;
        cont_d      = '0;
        seq_len_d   = '0;
        lead_d      = '0;
        lead_pend_d = 1'b0;
        written_d   = '0;
        err_latch_d = 1'b0;
      end else if (err_latch_q) begin
        err_latch_d = 1'b1;
      end else if (fin_err != ERR_NONE) begin
        pcp_d       = '0;
        cont_d      = '0;
        seq_len_d   = '0;
        lead_d      = '0;
        lead_pend_d = 1'b0;
        err_latch_d = 1'b1;
      end else begin
        pcp_d       = dec_pcp;
        cont_d      = dec_cont;
        seq_len_d   = dec_seq_len;
        lead_d      = dec_lead;
        lead_pend_d = dec_lead_pend;
        if (emit) begin
          written_d = new_total[CapW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q       <= '0;
      cont_q      <= '0;
      seq_len_q   <= '0;
      lead_q      <= '0;
      lead_pend_q <= 1'b0;
      written_q   <= '0;
      err_latch_q <= 1'b0;
    end else begin
      pcp_q       <= pcp_d;
      cont_q      <= cont_d;
      seq_len_q   <= seq_len_d;
      lead_q      <= lead_d;
      lead_pend_q <= lead_pend_d;
      written_q   <= written_d;
      err_latch_q <= err_latch_d;
    end
  end

endmodule

`default_nettype wire

>>> design/utc_queue.sv
// ----------------------------------------------------------------------------
// utc_queue: run queue between front end and back end
// A small register queue of run records with concurrent push and pop.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_queue import utc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire utc_run_t push_data_i,
  input  wire logic     pop_i,
  output logic          full_o,
  output logic          valid_o,
  output utc_run_t      head_o
);

  utc_run_t             entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = count_q == QueueCntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> design/utc_back.sv
// ----------------------------------------------------------------------------
// utc_back: result serializer of the transcoder
// Walks the units of the run at the head of the queue and presents one
// result per cycle, unless the output stalls, from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_back import utc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire utc_run_t         head_i,
  input  wire logic             head_valid_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [UnitW-1:0]      target_unit_o,
  output logic                  run_end_o,
  output logic                  string_end_o,
  output logic [2:0]            error_code_o
);

  logic [1:0]       idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [UnitW-1:0] unit_q;
  logic             run_end_q;
  logic             string_end_q;
  utc_err_e         err_q;
  logic             load;
  logic             last;

  assign load  = head_valid_i && (!valid_q || !out_stall_i);
  assign last  = idx_q == head_i.last_idx;
  assign pop_o = load && last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = last ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q       <= head_i.units[idx_q];
      run_end_q    <= last;
      string_end_q <= last && head_i.fin;
      err_q        <= head_i.err;
    end
  end

  assign out_valid_o   = valid_q;
  assign target_unit_o = unit_q;
  assign run_end_o     = run_end_q;
  assign string_end_o  = string_end_q;
  assign error_code_o  = err_q;

endmodule

`default_nettype wire

>>> design/utf_code_unit_transcoder.sv
// ----------------------------------------------------------------------------
// utf_code_unit_transcoder: streaming ASCII/UTF-8/UTF-16/UTF-32 transcoder
// Decodes source code units, validates code points and re-encodes them in
// the target encoding under a per-string capacity limit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid_i/in_stall_o   source_unit_i, final_unit_i
//   output    out        out_valid_o/out_stall_i target_unit_o, run_end_o,
//                                                string_end_o, error_code_o
//   config    in         cfg_we_i                cfg_index_i, cfg_data_i
//
// One source unit is accepted per cycle while the run queue has room; the
// unit is decoded and encoded in the cycle of its transfer.
// The back end delivers one result per cycle while the output is not stalled,
// so a code point that becomes N target units takes N output results; the
// queue of four runs lets the input run ahead of that.
// Reset is asynchronous and active low and restores the register defaults
// (UTF-8 to UTF-8, capacity 64) and an empty string state.
// Either side may stall at any time: the output register holds its result
// and the input stalls only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module utf_code_unit_transcoder import utc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Source units
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [UnitW-1:0] source_unit_i,
  input  wire logic             final_unit_i,
  // Target units and status
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [UnitW-1:0]      target_unit_o,
  output logic                  run_end_o,
  output logic                  string_end_o,
  output logic [2:0]            error_code_o,
  // Register writes
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CfgW-1:0]  cfg_data_i
);

  utc_cfg_t cfg_q, cfg_d;
  logic     src_enc_wr;
  logic     accept;
  logic     push;
  utc_run_t push_data;
  logic     q_full;
  logic     q_valid;
  utc_run_t q_head;
  logic     pop;

  // Register file. Writing the source encoding also flushes any partial
  // decode in the front end.
  assign src_enc_wr = cfg_we_i && (cfg_index_i == CFG_SOURCE_ENC);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SOURCE_ENC: cfg_d.src_enc = utc_enc_e'(cfg_data_i[1:0]);
        CFG_TARGET_ENC: cfg_d.tgt_enc = utc_enc_e'(cfg_data_i[1:0]);
        CFG_TARGET_CAP: cfg_d.cap     = cfg_data_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_enc <= ENC_UTF8;
      cfg_q.tgt_enc <= ENC_UTF8;
      cfg_q.cap     <= CapW'(64);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The input stalls only on a full queue; a unit that causes no result
  // pushes nothing.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  utc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .src_enc_wr_i  (src_enc_wr),
    .accept_i      (accept),
    .source_unit_i (source_unit_i),
    .final_unit_i  (final_unit_i),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  utc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  utc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .head_valid_i  (q_valid),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .target_unit_o (target_unit_o),
    .run_end_o     (run_end_o),
    .string_end_o  (string_end_o),
    .error_code_o  (error_code_o)
  );

  // A string can only close on the last result of a run.
  a_string_end_on_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_end_o)
    else $error("string end outside the last result of a run");

  // Status results stand alone and carry no unit.
  a_error_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_NONE) |-> run_end_o && (target_unit_o == '0))
    else $error("error result carries a unit or is not alone");

  // A push is never lost to a full queue.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("run pushed into a full queue");

  // The back end only pops a run that is present.
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire
